// ===== sv/ps2dt_pkg.sv =====
`timescale 1ns / 1ps

package ps2dt_pkg;

  localparam int unsigned HoldW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned HostW = 2;
  localparam int unsigned FrameW = 11;

  localparam logic [HoldW-1:0] HoldReset = 16'd200;
  localparam int unsigned FifoDepthDefault = 32;

  localparam logic [HostW-1:0] HostReleased = 2'd0;
  localparam logic [HostW-1:0] HostInhibited = 2'd1;

  localparam logic ReqTick = 1'b0;
  localparam logic ReqPush = 1'b1;

endpackage

// ===== sv/ps2_device_byte_transmitter.sv =====
`timescale 1ns / 1ps

// each accepted item's result is registered in the output register in the next cycle
// throughput: one item per cycle; in_ready_o drops only while a result waits
// the byte fifo is a memory with one write port and one registered read port
// reset clears the sender, fifo pointers and line levels (both low), hold 200
// fifo contents are not cleared and only written entries are ever read
module ps2_device_byte_transmitter #(
  parameter int unsigned FIFO_DEPTH = ps2dt_pkg::FifoDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          hold_ticks_we_i,
  input  logic [ps2dt_pkg::HoldW-1:0]   hold_ticks_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ps2dt_pkg::DataW-1:0]   push_byte_i,
  input  logic [ps2dt_pkg::HostW-1:0]   host_state_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          clock_line_o,
  output logic                          data_line_o,
  output logic                          byte_dropped_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  localparam logic [1:0] PhReady = 2'd0;
  localparam logic [1:0] PhLow = 2'd1;
  localparam logic [1:0] PhHigh = 2'd2;

  logic [ps2dt_pkg::HoldW-1:0]  hold_q;
  logic [1:0]                   phase_q, phase_d;
  logic [ps2dt_pkg::DataW-1:0]  held_q, held_d;
  logic [ps2dt_pkg::FrameW-1:0] frame_q, frame_d;
  logic [ps2dt_pkg::HoldW-1:0]  ticks_q, ticks_d;
  logic [PtrW-1:0]              rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]              wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         clk_q, clk_d;
  logic                         dat_q, dat_d;
  logic                         drop_q, drop_d;
  logic                         out_valid_q, out_valid_d;

  logic [ps2dt_pkg::DataW-1:0]  mem [FIFO_DEPTH];
  logic [ps2dt_pkg::DataW-1:0]  rd_data_q;

  logic accept;
  logic push_en;
  logic pop_en;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    logic                         idle_v;
    logic [1:0]                   ph_v;
    logic [ps2dt_pkg::FrameW-1:0] fr_v;
    logic [ps2dt_pkg::HoldW-1:0]  tk_v;
    logic [ps2dt_pkg::HoldW-1:0]  tk_inc;
    logic [ps2dt_pkg::DataW-1:0]  byte_v;
    idle_v = (phase_q != PhLow) && (phase_q != PhHigh);
    ph_v = phase_q;
    fr_v = frame_q;
    tk_v = ticks_q;
    tk_inc = '0;
    byte_v = held_q;
    phase_d = phase_q;
    held_d = held_q;
    frame_d = frame_q;
    ticks_d = ticks_q;
    clk_d = clk_q;
    dat_d = dat_q;
    drop_d = drop_q;
    push_en = 1'b0;
    pop_en = 1'b0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      drop_d = 1'b0;
      if (req_type_i == ps2dt_pkg::ReqPush) begin
        if (cnt_q == CntFull) begin
          drop_d = 1'b1;
        end else begin
          push_en = 1'b1;
        end
      end else begin
        case (host_state_i)
          ps2dt_pkg::HostInhibited: begin
            clk_d = 1'b0;
            dat_d = 1'b0;
            phase_d = PhReady;
          end
          ps2dt_pkg::HostReleased: begin
            if (idle_v && frame_q == '0 && cnt_q == '0) begin
              clk_d = 1'b1;
              dat_d = 1'b0;
            end else begin
              if (idle_v) begin
                if (frame_q == '0) begin
                  pop_en = 1'b1;
                  byte_v = rd_data_q;
                  held_d = rd_data_q;
                end
                fr_v = {1'b1, ~^byte_v, byte_v, 1'b0};
                tk_v = '0;
                ph_v = PhLow;
              end
              tk_inc = tk_v + 1'b1;
              if (ph_v == PhLow) begin
                clk_d = 1'b0;
                dat_d = fr_v[0];
                if (tk_inc == hold_q) begin
                  frame_d = fr_v >> 1;
                  phase_d = PhHigh;
                  ticks_d = '0;
                end else begin
                  frame_d = fr_v;
                  phase_d = PhLow;
                  ticks_d = tk_inc;
                end
              end else begin
                clk_d = 1'b1;
                dat_d = 1'b0;
                ticks_d = tk_inc;
                if (tk_inc == hold_q) begin
                  if (fr_v != '0) begin
                    ticks_d = '0;
                    phase_d = PhLow;
                  end else begin
                    phase_d = PhReady;
                  end
                end
              end
            end
          end
          default: begin
            clk_d = 1'b0;
            dat_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push_en) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[wr_ptr_q] <= push_byte_i;
    end
    if (push_en && wr_ptr_q == rd_ptr_d) begin
      rd_data_q <= push_byte_i;
    end else begin
      rd_data_q <= mem[rd_ptr_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= ps2dt_pkg::HoldReset;
      phase_q <= PhReady;
      held_q <= '0;
      frame_q <= '0;
      ticks_q <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q <= '0;
      clk_q <= 1'b0;
      dat_q <= 1'b0;
      drop_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (hold_ticks_we_i) begin
        hold_q <= hold_ticks_i;
      end
      phase_q <= phase_d;
      held_q <= held_d;
      frame_q <= frame_d;
      ticks_q <= ticks_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q <= cnt_d;
      clk_q <= clk_d;
      dat_q <= dat_d;
      drop_q <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clock_line_o = clk_q;
  assign data_line_o = dat_q;
  assign byte_dropped_o = drop_q;

endmodule

// ===== sv/ps2dt_checker.sv =====
`timescale 1ns / 1ps

module ps2dt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        req_type_i,
  input logic [ps2dt_pkg::HostW-1:0] host_state_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        clock_line_o,
  input logic                        data_line_o,
  input logic                        byte_dropped_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // ready only drops while a result waits
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(clock_line_o)
      && $stable(data_line_o) && $stable(byte_dropped_o))
    else $error("stalled result changed");

  // every item leaves a result, and ticks never flag a drop
  a_tick_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == ps2dt_pkg::ReqTick |=> out_valid_o && !byte_dropped_o)
    else $error("tick item flagged a drop");

  // a host that is not released pulls both lines low
  a_host_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == ps2dt_pkg::ReqTick
      && host_state_i != ps2dt_pkg::HostReleased
      |=> !clock_line_o && !data_line_o)
    else $error("lines driven while host not released");

  // a push leaves the line levels as they were
  a_push_keeps_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == ps2dt_pkg::ReqPush && $past(rst_ni)
      |=> $stable(clock_line_o) && $stable(data_line_o))
    else $error("push changed line levels");

endmodule

bind ps2_device_byte_transmitter ps2dt_checker u_ps2dt_checker (.*);
